// ===== rtl/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants of the text command parser
// character codes, keyword tables, command codes and the header control word
// ----------------------------------------------------------------------------
package tcp_pkg;

  // longest accepted message is MaxMsgLen-1 bytes including the ';'
  localparam int unsigned MaxMsgLen = 128;
  localparam int unsigned MsgLenW   = $clog2(MaxMsgLen + 1);

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // keywords, right-aligned with the first character at the high end
  localparam int unsigned TxtW = 64;
  localparam int unsigned NumGrp = 2;
  localparam int unsigned NumSub = 5;

  localparam logic [TxtW-1:0] GrpTxt [NumGrp] = '{TxtW'("flash"), TxtW'("trig")};
  localparam logic [2:0]      GrpLen [NumGrp] = '{3'd5, 3'd4};
  localparam logic [TxtW-1:0] SubTxt [NumSub] = '{TxtW'("on"), TxtW'("off"),
                                                 TxtW'("en"), TxtW'("shift"),
                                                 TxtW'("expo")};
  localparam logic [2:0]      SubLen [NumSub] = '{3'd2, 3'd3, 3'd2, 3'd5, 3'd4};

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_FLASH_ON  = 3'd1,
    CMD_FLASH_OFF = 3'd2,
    CMD_TRIG_EN   = 3'd3,
    CMD_TRIG_OFF  = 3'd4,
    CMD_TRIG_SHIFT = 3'd5,
    CMD_TRIG_EXPO = 3'd6
  } cmd_e;

  // what the top level asks the header matcher to do with the current word
  typedef struct packed {
    logic step;     // a word is processed this cycle
    logic clear;    // end of message, back to reset
    logic close;    // '.' or ':' in the header
    logic is_char;  // ordinary header character
  } hdr_ctrl_t;

  // does character ch sit at position idx of keyword txt of length len
  function automatic logic char_hit(logic [TxtW-1:0] txt, logic [2:0] len,
                                    logic [6:0] idx, logic [7:0] ch);
    logic [2:0] pos;
    logic [5:0] base;
    pos  = 3'(len - 3'd1 - idx[2:0]);
    base = {pos, 3'b000};
    return (idx < 7'(len)) && (txt[base +: 8] == ch);
  endfunction

endpackage

// ===== rtl/tcp_header.sv =====
// ----------------------------------------------------------------------------
// tcp_header: header token matcher
// splits the header on '.' and ':', tracks keyword candidates and gives the command
// ----------------------------------------------------------------------------
module tcp_header (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcp_pkg::hdr_ctrl_t ctrl_i,
  input  logic [7:0]        ch_i,
  output logic [2:0]        command_o
);

  localparam logic [1:0] GM_NONE  = 2'd0;
  localparam logic [1:0] GM_FLASH = 2'd1;
  localparam logic [1:0] GM_TRIG  = 2'd2;

  logic [2:0] tok_cnt_q, tok_cnt_d;
  logic [6:0] idx_q, idx_d;
  logic [1:0] grp_live_q, grp_live_d;
  logic [1:0] grp_match_q, grp_match_d;
  logic [tcp_pkg::NumSub-1:0] sub_q, sub_d;

  logic [2:0] tc_new;
  logic [1:0] grp_hit;
  logic [tcp_pkg::NumSub-1:0] sub_hit, sub_len_ok;

  always_comb begin
    for (int k = 0; k < tcp_pkg::NumGrp; k++) begin
      grp_hit[k] = tcp_pkg::char_hit(tcp_pkg::GrpTxt[k], tcp_pkg::GrpLen[k], idx_q, ch_i);
    end
    for (int k = 0; k < tcp_pkg::NumSub; k++) begin
      sub_hit[k]    = tcp_pkg::char_hit(tcp_pkg::SubTxt[k], tcp_pkg::SubLen[k], idx_q, ch_i);
      sub_len_ok[k] = (idx_q == 7'(tcp_pkg::SubLen[k]));
    end
  end

  // a fresh token bumps the count, saturating at seven
  assign tc_new = (idx_q == '0 && tok_cnt_q != 3'd7) ? tok_cnt_q + 3'd1 : tok_cnt_q;

  always_comb begin
    tok_cnt_d   = tok_cnt_q;
    idx_d       = idx_q;
    grp_live_d  = grp_live_q;
    grp_match_d = grp_match_q;
    sub_d       = sub_q;
    if (ctrl_i.step) begin
      if (ctrl_i.clear) begin
        tok_cnt_d   = '0;
        idx_d       = '0;
        grp_live_d  = '1;
        grp_match_d = GM_NONE;
        sub_d       = '1;
      end else if (ctrl_i.close) begin
        if (idx_q != '0) begin
          if (tok_cnt_q == 3'd1) begin
            if (grp_live_q[0] && idx_q == 7'(tcp_pkg::GrpLen[0])) begin
              grp_match_d = GM_FLASH;
            end else if (grp_live_q[1] && idx_q == 7'(tcp_pkg::GrpLen[1])) begin
              grp_match_d = GM_TRIG;
            end else begin
              grp_match_d = GM_NONE;
            end
          end else if (tok_cnt_q == 3'd2) begin
            sub_d = sub_q & sub_len_ok;
          end
          idx_d = '0;
        end
      end else if (ctrl_i.is_char) begin
        tok_cnt_d = tc_new;
        if (tc_new == 3'd1) begin
          grp_live_d = ((idx_q == '0) ? 2'b11 : grp_live_q) & grp_hit;
        end else if (tc_new == 3'd2) begin
          sub_d = ((idx_q == '0) ? '1 : sub_q) & sub_hit;
        end
        if (idx_q != 7'd127) begin
          idx_d = idx_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_cnt_q   <= '0;
      idx_q       <= '0;
      grp_live_q  <= '1;
      grp_match_q <= GM_NONE;
      sub_q       <= '1;
    end else begin
      tok_cnt_q   <= tok_cnt_d;
      idx_q       <= idx_d;
      grp_live_q  <= grp_live_d;
      grp_match_q <= grp_match_d;
      sub_q       <= sub_d;
    end
  end

  // command from the finished header; flash: on, off; trig: en, off, shift, expo
  always_comb begin
    tcp_pkg::cmd_e cmd;
    cmd = tcp_pkg::CMD_NONE;
    if (tok_cnt_q >= 3'd2) begin
      case (grp_match_q)
        GM_FLASH: begin
          if (sub_q[0]) cmd = tcp_pkg::CMD_FLASH_ON;
          else if (sub_q[1]) cmd = tcp_pkg::CMD_FLASH_OFF;
        end
        GM_TRIG: begin
          if (sub_q[2]) cmd = tcp_pkg::CMD_TRIG_EN;
          else if (sub_q[1]) cmd = tcp_pkg::CMD_TRIG_OFF;
          else if (sub_q[3]) cmd = tcp_pkg::CMD_TRIG_SHIFT;
          else if (sub_q[4]) cmd = tcp_pkg::CMD_TRIG_EXPO;
        end
        default: cmd = tcp_pkg::CMD_NONE;
      endcase
    end
    command_o = cmd;
  end

endmodule

// ===== rtl/text_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// text_command_parser_top: byte-serial "group.sub:value;" command parser
// input register, single parse step, registered result word
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless a ';' is stalled, and each ';'
// that closes a valid message yields one result word (command code and signed
// 32-bit value) that is valid once that ';' has passed the input register and
// the result is held in the output register. The byte sits in an input
// register and is then folded into the header matcher, the number accumulator
// and the message length counter in a single step; a result goes to an output
// register, so bytes keep flowing while a result waits. The only stall: a ';'
// held in the input register waits while an untaken result still occupies the
// output register. Messages with no ':', with nothing after the ':', or longer
// than 127 bytes including the ';' give no result; unknown keywords give
// command 0. Every ';' returns the parser to its reset state.
module text_command_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         command_o,
  output logic signed [31:0] value_o
);

  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_VALUE  = 1'b1;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // parse state
  logic                        phase_q, phase_d;
  logic [tcp_pkg::MsgLenW-1:0] len_q, len_d, len_inc;
  logic [31:0]                 acc_q, acc_d;
  logic                        minus_q, minus_d;
  logic                        started_q, started_d;
  logic                        ended_q, ended_d;
  logic                        seen_q, seen_d;

  // output register
  logic        out_valid_q;
  logic [2:0]  command_q;
  logic [31:0] value_q;

  logic       is_semi, is_digit, is_blank, is_sign;
  logic       adv, accept, emit;
  logic [2:0] hdr_cmd;
  tcp_pkg::hdr_ctrl_t hdr_ctrl;

  assign is_semi  = (in_byte_q == tcp_pkg::ChSemi);
  assign is_digit = (in_byte_q >= tcp_pkg::ChZero) && (in_byte_q <= tcp_pkg::ChNine);
  assign is_blank = (in_byte_q == tcp_pkg::ChSpace) ||
                    ((in_byte_q >= tcp_pkg::ChTab) && (in_byte_q <= tcp_pkg::ChCr));
  assign is_sign  = (in_byte_q == tcp_pkg::ChPlus) || (in_byte_q == tcp_pkg::ChMinus);

  // a ';' needs a free output slot, every other byte moves on at once
  assign adv        = in_valid_q && (!is_semi || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // message length, saturating, counts the ';' too
  assign len_inc = (len_q < tcp_pkg::MsgLenW'(tcp_pkg::MaxMsgLen)) ? len_q + 1'b1 : len_q;
  assign accept  = (len_inc <= tcp_pkg::MsgLenW'(tcp_pkg::MaxMsgLen - 1)) &&
                   (phase_q == PH_VALUE) && seen_q;
  assign emit    = adv && is_semi && accept;

  // header matcher control
  always_comb begin
    hdr_ctrl.step    = adv;
    hdr_ctrl.clear   = is_semi;
    hdr_ctrl.close   = (phase_q == PH_HEADER) &&
                       (in_byte_q == tcp_pkg::ChColon || in_byte_q == tcp_pkg::ChDot);
    hdr_ctrl.is_char = (phase_q == PH_HEADER);
  end

  tcp_header u_header (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hdr_ctrl),
    .ch_i      (in_byte_q),
    .command_o (hdr_cmd)
  );

  // phase, length and number accumulator
  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    acc_d     = acc_q;
    minus_d   = minus_q;
    started_d = started_q;
    ended_d   = ended_q;
    seen_d    = seen_q;
    if (adv) begin
      len_d = len_inc;
      if (is_semi) begin
        // every ';' ends the message, kept or dropped
        phase_d   = PH_HEADER;
        len_d     = '0;
        acc_d     = '0;
        minus_d   = 1'b0;
        started_d = 1'b0;
        ended_d   = 1'b0;
        seen_d    = 1'b0;
      end else if (phase_q == PH_HEADER) begin
        if (in_byte_q == tcp_pkg::ChColon) begin
          phase_d = PH_VALUE;
        end
      end else begin
        seen_d = 1'b1;
        if (ended_q) begin
          // number already finished, rest of the text is ignored
        end else if (!started_q && is_blank) begin
          // leading blanks skipped
        end else if (!started_q && is_sign) begin
          started_d = 1'b1;
          minus_d   = (in_byte_q == tcp_pkg::ChMinus);
        end else if (is_digit) begin
          started_d = 1'b1;
          // acc * 10 + digit, wraps modulo 2^32
          acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, in_byte_q[3:0]};
        end else begin
          ended_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      len_q     <= '0;
      acc_q     <= '0;
      minus_q   <= 1'b0;
      started_q <= 1'b0;
      ended_q   <= 1'b0;
      seen_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      acc_q     <= acc_d;
      minus_q   <= minus_d;
      started_q <= started_d;
      ended_q   <= ended_d;
      seen_q    <= seen_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      command_q <= hdr_cmd;
      value_q   <= minus_q ? (32'd0 - acc_q) : acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = command_q;
  assign value_o     = signed'(value_q);

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !emit)
    else $error("result overwritten while waiting");

  // every processed ';' returns the parser to reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_semi |=> len_q == '0 && phase_q == PH_HEADER && !seen_q && acc_q == '0)
    else $error("state not cleared after end of message");

  // a stalled input word stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input word lost");

  // only known command codes are produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> command_o <= 3'(tcp_pkg::CMD_TRIG_EXPO))
    else $error("command code out of range");

endmodule

// ===== tb/text_command_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_parser_checker: result predictor and scoreboard
// mirrors the byte parser on every accepted input word and compares each
// accepted result word against the oldest predicted command
// ----------------------------------------------------------------------------
module text_command_parser_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [1:0] {
    GRP_NONE  = 2'd0,
    GRP_FLASH = 2'd1,
    GRP_TRIG  = 2'd2
  } grp_e;

  // bit positions in the sub-keyword candidate vector
  localparam int SubOn    = 0;
  localparam int SubOff   = 1;
  localparam int SubEn    = 2;
  localparam int SubShift = 3;
  localparam int SubExpo  = 4;

  typedef struct packed {
    tcp_pkg::cmd_e cmd;
    logic [31:0]   val;
  } parsed_cmd_t;

  string grp_word [2] = '{"flash", "trig"};
  string sub_word [5] = '{"on", "off", "en", "shift", "expo"};

  logic        in_value;     // past the first ':'
  logic [2:0]  tok_cnt;
  logic [6:0]  tok_idx;
  logic [1:0]  grp_live;
  grp_e        grp_hit;
  logic [4:0]  sub_live;
  logic [31:0] num_mag;
  logic        num_neg;
  logic        num_start;
  logic        num_end;
  logic        value_seen;
  int          msg_len;

  parsed_cmd_t pending_cmds [$];

  function automatic void clear_state();
    in_value   = 1'b0;
    tok_cnt    = '0;
    tok_idx    = '0;
    grp_live   = 2'b11;
    grp_hit    = GRP_NONE;
    sub_live   = 5'b11111;
    num_mag    = '0;
    num_neg    = 1'b0;
    num_start  = 1'b0;
    num_end    = 1'b0;
    value_seen = 1'b0;
    msg_len    = 0;
  endfunction

  // end of a header token: decide group, prune sub candidates by length
  function automatic void close_word();
    if (tok_idx == 0) return;
    if (tok_cnt == 1) begin
      if (grp_live[0] && tok_idx == grp_word[0].len()) grp_hit = GRP_FLASH;
      else if (grp_live[1] && tok_idx == grp_word[1].len()) grp_hit = GRP_TRIG;
      else grp_hit = GRP_NONE;
    end else if (tok_cnt == 2) begin
      for (int k = 0; k < 5; k++)
        if (sub_word[k].len() != tok_idx) sub_live[k] = 1'b0;
    end
    tok_idx = '0;
  endfunction

  task automatic parse_byte(input logic [7:0] ch);
    tcp_pkg::cmd_e cmd;
    parsed_cmd_t   item;
    if (msg_len < tcp_pkg::MaxMsgLen) msg_len++;
    if (ch == tcp_pkg::ChSemi) begin
      if (msg_len <= tcp_pkg::MaxMsgLen - 1 && in_value && value_seen) begin
        cmd = tcp_pkg::CMD_NONE;
        if (tok_cnt >= 2) begin
          if (grp_hit == GRP_FLASH) begin
            if (sub_live[SubOn]) cmd = tcp_pkg::CMD_FLASH_ON;
            else if (sub_live[SubOff]) cmd = tcp_pkg::CMD_FLASH_OFF;
          end else if (grp_hit == GRP_TRIG) begin
            if (sub_live[SubEn]) cmd = tcp_pkg::CMD_TRIG_EN;
            else if (sub_live[SubOff]) cmd = tcp_pkg::CMD_TRIG_OFF;
            else if (sub_live[SubShift]) cmd = tcp_pkg::CMD_TRIG_SHIFT;
            else if (sub_live[SubExpo]) cmd = tcp_pkg::CMD_TRIG_EXPO;
          end
        end
        item.cmd = cmd;
        item.val = num_neg ? (32'd0 - num_mag) : num_mag;
        pending_cmds.push_back(item);
      end
      clear_state();
    end else if (!in_value) begin
      if (ch == tcp_pkg::ChColon) begin
        close_word();
        in_value = 1'b1;
      end else if (ch == tcp_pkg::ChDot) begin
        close_word();
      end else begin
        if (tok_idx == 0) begin
          if (tok_cnt < 7) tok_cnt++;
          if (tok_cnt == 1) grp_live = 2'b11;
          else if (tok_cnt == 2) sub_live = 5'b11111;
        end
        if (tok_cnt == 1) begin
          for (int k = 0; k < 2; k++)
            if (!(tok_idx < grp_word[k].len() && 8'(grp_word[k][tok_idx]) == ch))
              grp_live[k] = 1'b0;
        end else if (tok_cnt == 2) begin
          for (int k = 0; k < 5; k++)
            if (!(tok_idx < sub_word[k].len() && 8'(sub_word[k][tok_idx]) == ch))
              sub_live[k] = 1'b0;
        end
        if (tok_idx < 127) tok_idx++;
      end
    end else begin
      value_seen = 1'b1;
      if (!num_end) begin
        if (!num_start && (ch == tcp_pkg::ChSpace ||
                           (ch >= tcp_pkg::ChTab && ch <= tcp_pkg::ChCr))) begin
          // leading blank, skipped
        end else if (!num_start && (ch == tcp_pkg::ChPlus || ch == tcp_pkg::ChMinus)) begin
          num_start = 1'b1;
          if (ch == tcp_pkg::ChMinus) num_neg = 1'b1;
        end else if (ch >= tcp_pkg::ChZero && ch <= tcp_pkg::ChNine) begin
          num_start = 1'b1;
          num_mag   = num_mag * 32'd10 + 32'(ch - tcp_pkg::ChZero);
        end else begin
          num_end = 1'b1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_cmd_t want;
    if (!rst_ni) begin
      clear_state();
      pending_cmds.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected word command=%0d value=%0d",
                                    command_i, value_i));
        end else begin
          want = pending_cmds.pop_front();
          if (command_i !== want.cmd)
            report_mismatch($sformatf("command %0d, predicted %0d", command_i, want.cmd));
          if (value_i !== want.val)
            report_mismatch($sformatf("value %0d, predicted %0d",
                                      value_i, $signed(want.val)));
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(rx_byte_i);
      pending_o <= pending_cmds.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the text command parser
// feeds command text byte by byte, first hand-picked messages and corner
// cases, then random well-formed and broken messages under three idle mixes;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;

  // receiver hold-off long enough to fill the output and input registers
  localparam int HoldCycles = 400;
  // least number of random bytes sent in each idle mix
  localparam int PhaseBytes = 180;
  localparam logic [7:0] NulByte = 8'h00;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [7:0]        rx_byte   = 8'h00;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [2:0]        command;
  logic signed [31:0] value;
  int                fail_count;
  int                pending;

  // idle rates in percent, changed between phases
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  // hold-off requests from the stimulus, served by the receiver process
  int hold_reqs  = 0;
  int holds_done = 0;
  int bytes_sent = 0;

  // message under construction, sent as a whole
  logic [7:0] msg_q [$];

  string sub_kw [5] = '{"on", "off", "en", "shift", "expo"};

  always #5 clk = ~clk;

  text_command_parser_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .command_o   (command),
    .value_o     (value)
  );

  text_command_parser_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .command_i    (command),
    .value_i      (value),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stalls, plus a long hold-off when the stimulus asks
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it; valid stays up
  // between back-to-back words so it is never lowered and raised in one step
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) send_byte(msg_q[i]);
    msg_q.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_msg();
  endtask

  // sender goes quiet until every predicted result has been taken
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // a header token: mostly the keyword, sometimes a near miss, random
  // letters or nothing at all (gives an empty token between dots)
  task automatic add_word(input string kw);
    string w;
    case ($urandom_range(9))
      6: begin
        w = kw;
        w[$urandom_range(kw.len() - 1)] = "q";
        add_text(w);
      end
      7: begin
        if ($urandom_range(1)) add_text(kw.substr(0, kw.len() - 2));
        else add_text({kw, "x"});
      end
      8: repeat ($urandom_range(1, 6))
           msg_q.push_back(8'($urandom_range(8'h61, 8'h7A)));  // lower-case letter
      9: ;
      default: add_text(kw);
    endcase
  endtask

  // one random message: mostly group.sub:value; with random content,
  // some raw noise over the full byte range, some padded past the length limit
  task automatic build_message();
    int kind;
    int goal;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom_range(255)));
      msg_q.push_back(tcp_pkg::ChSemi);
      return;
    end
    // header, with stray dots and the odd extra token
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
      msg_q.push_back(tcp_pkg::ChDot);
    add_word($urandom_range(1) ? "flash" : "trig");
    repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2))
      msg_q.push_back(tcp_pkg::ChDot);
    add_word(sub_kw[$urandom_range(4)]);
    if ($urandom_range(4) == 0) begin
      msg_q.push_back(tcp_pkg::ChDot);
      add_word(sub_kw[$urandom_range(4)]);
    end
    if ($urandom_range(19) != 0) msg_q.push_back(tcp_pkg::ChColon);
    // value: blanks, sign, digits, then maybe a stray byte
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
      msg_q.push_back($urandom_range(1) ? tcp_pkg::ChSpace
                                        : 8'($urandom_range(tcp_pkg::ChTab, tcp_pkg::ChCr)));
    case ($urandom_range(3))
      0: msg_q.push_back(tcp_pkg::ChMinus);
      1: msg_q.push_back(tcp_pkg::ChPlus);
      default: ;
    endcase
    case ($urandom_range(3))
      0: ;
      1: add_text($sformatf("%0d", $urandom()));
      default: repeat ($urandom_range(1, 12))
                 msg_q.push_back(8'(tcp_pkg::ChZero + $urandom_range(9)));
    endcase
    if ($urandom_range(5) == 0) msg_q.push_back(8'($urandom_range(255)));
    // around the length limit: 127 bytes with the ';' still passes
    if (kind < 16) begin
      goal = $urandom_range(120, 134);
      while (msg_q.size() < goal - 1) msg_q.push_back("x");
    end
    msg_q.push_back(tcp_pkg::ChSemi);
  endtask

  initial begin : stimulus
    int start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 15;
    rcv_idle_pct = 70;

    // every command and both value extremes
    send_text("flash.on:0;");
    send_text("flash.off:-2147483648;");
    send_text("trig.en:2147483647;");
    send_text("trig.off:+42;");
    // all six blank characters before the sign
    send_text("trig.shift:\011\012\013\014\015 -17;");
    // magnitude wraps around 2^32
    send_text("trig.expo:4294967295;");
    send_text("trig.expo:99999999999;");
    // empty tokens skipped, tokens past the second ignored
    send_text("..trig...expo..extra.more:12;");
    // missing second token, missing both tokens
    send_text("trig:5;");
    send_text(":5;");
    // no colon, empty value, blank-only value
    send_text("flash.on;");
    send_text("flash.on:;");
    send_text("flash.on: ;");
    // unknown words and mismatched pairs give command none
    send_text("foo.bar:3;");
    send_text("flash.en:1;");
    send_text("trig.on:1;");
    send_text("flas.o:1;");
    send_text("flashy.onn:1;");
    // number stops at the first non-digit
    send_text("flash.on:12abc34;");
    send_text("flash.on:--5;");
    send_text("flash.on:5:6;");
    send_text(";");
    // zero byte in the value, all-ones byte in the header
    add_text("trig.off:12");
    msg_q.push_back(NulByte);
    send_text("3;");
    add_text("flash.o");
    msg_q.push_back(8'hFF);
    send_text("n:9;");
    // 127 bytes accepted, 128 bytes dropped
    for (int pad = 114; pad <= 115; pad++) begin
      add_text("trig.shift:");
      repeat (pad) msg_q.push_back(tcp_pkg::ChSpace);
      send_text("7;");
    end
    wait_results();

    // random part: receiver slow, then sender slow, then flat out
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 15; rcv_idle_pct = 70; end
        1: begin snd_idle_pct = 70; rcv_idle_pct = 15; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if (ph == 2) begin
        // receiver stops while results keep coming: input must back up
        hold_reqs <= hold_reqs + 1;
        repeat (6) send_text("trig.shift:-3;");
      end
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        build_message();
        send_msg();
      end
      wait_results();
    end

    // drain: a late extra word would show up as a mismatch here
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("text_command_parser_top test passed");
    end else begin
      $display("text_command_parser_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("text_command_parser_top test failed");
    $finish;
  end

endmodule
